// ===== rtl/i2c_bus_recovery_sequencer_unit_defines.svh =====
// Assertion macros for the I2C bus recovery sequencer.
// No dependencies; included by the top level only.
`ifndef I2C_BUS_RECOVERY_SEQUENCER_UNIT_DEFINES_SVH
`define I2C_BUS_RECOVERY_SEQUENCER_UNIT_DEFINES_SVH

// Concurrent check that is switched off while reset is asserted.
`define I2CBR_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("i2cbr check failed");

// Concurrent check that also holds during reset.
`define I2CBR_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) (prop)) \
    else $error("i2cbr check failed");

`endif

// ===== rtl/i2cbr_pkg.sv =====
// Shared types and constants for the I2C bus recovery sequencer.
// No dependencies; used by i2cbr_cfg, i2cbr_seq and the top level.
package i2cbr_pkg;

  // Default width of the wait counter.
  localparam int unsigned TimerBitsDefault = 22;

  // Register widths.
  localparam int unsigned SettleW   = 22;
  localparam int unsigned HalfW     = 10;
  localparam int unsigned PollW     = 18;
  localparam int unsigned CountW    = 6;
  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 22;

  // Register reset values.
  localparam logic [SettleW-1:0] SettleRst = 22'd2500000;
  localparam logic [HalfW-1:0]   HalfRst   = 10'd10;
  localparam logic [PollW-1:0]   PollRst   = 18'd100000;
  localparam logic [CountW-1:0]  PLimitRst = 6'd20;
  localparam logic [CountW-1:0]  CLimitRst = 6'd20;

  // Register indexes on the configuration port.
  typedef enum logic [CfgIndexW-1:0] {
    CFG_SETTLE  = 3'd0,
    CFG_HALF    = 3'd1,
    CFG_POLL    = 3'd2,
    CFG_PLIMIT  = 3'd3,
    CFG_CLIMIT  = 3'd4
  } cfg_idx_e;

  // Outcome codes of a recovery run.
  typedef enum logic [1:0] {
    OUT_CLEARED = 2'd0,
    OUT_SCL_LOW = 2'd1,
    OUT_STRETCH = 2'd2,
    OUT_SDA_LOW = 2'd3
  } outcome_e;

  // Sequencer phases.
  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_SETTLE = 3'd1,
    PH_LOW    = 3'd2,
    PH_HIGH   = 3'd3,
    PH_POLL   = 3'd4,
    PH_START  = 3'd5,
    PH_STOP   = 3'd6
  } phase_e;

  // Current register settings handed to the sequencer.
  typedef struct packed {
    logic [SettleW-1:0] settle_ticks;
    logic [HalfW-1:0]   half_period_ticks;
    logic [PollW-1:0]   poll_ticks;
    logic [CountW-1:0]  poll_limit;
    logic [CountW-1:0]  clock_limit;
  } cfg_t;

  // One request as it leaves the input register.
  typedef struct packed {
    logic kind;
    logic scl_level;
    logic sda_level;
  } item_t;

endpackage

// ===== rtl/i2c_bus_recovery_sequencer_unit.sv =====
// Top level of the I2C bus recovery sequencer: input register, handshake, result valid.
// Depends on i2cbr_pkg, i2cbr_cfg, i2cbr_seq and the assertion macro header.
//
//  Channel   Direction  Handshake              Payload
//  in        sink       in_valid_i/in_stall_o  kind_i, scl_level_i, sda_level_i
//  out       source     out_valid_o/out_stall_i scl_pull_low_o, sda_pull_low_o,
//                                              busy_res_o, finished_o, outcome_o
//  cfg       sink       cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// A request is taken into the input register, and the sequencer then updates
// its state, which is the result, once the result register is free or is taken.
// One request per cycle is sustained while the result is not stalled.
// Reset returns the sequencer to idle and the registers to their defaults.
// A stalled result holds; the input register keeps taking a request while
// the result register is free or is being taken.
`include "i2c_bus_recovery_sequencer_unit_defines.svh"

module i2c_bus_recovery_sequencer_unit #(
  parameter int unsigned TIMER_BITS = i2cbr_pkg::TimerBitsDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            kind_i,
  input  logic                            scl_level_i,
  input  logic                            sda_level_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            scl_pull_low_o,
  output logic                            sda_pull_low_o,
  output logic                            busy_res_o,
  output logic                            finished_o,
  output logic [1:0]                      outcome_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [i2cbr_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [i2cbr_pkg::CfgDataW-1:0]  cfg_data_i
);
  import i2cbr_pkg::*;

  item_t item_q;
  logic  in_valid_q, in_valid_d;
  logic  out_valid_q, out_valid_d;
  logic  out_free, step, in_take;
  cfg_t  cfg;

  // Pipeline control.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take)   in_valid_d = 1'b1;
    else if (step) in_valid_d = 1'b0;

    out_valid_d = out_valid_q;
    if (step)              out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Input payload register.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.kind      <= kind_i;
      item_q.scl_level <= scl_level_i;
      item_q.sda_level <= sda_level_i;
    end
  end

  assign out_valid_o = out_valid_q;

  i2cbr_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  i2cbr_seq #(
    .TIMER_BITS (TIMER_BITS)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .item_i         (item_q),
    .cfg_i          (cfg),
    .scl_pull_low_o (scl_pull_low_o),
    .sda_pull_low_o (sda_pull_low_o),
    .busy_res_o     (busy_res_o),
    .finished_o     (finished_o),
    .outcome_o      (outcome_o)
  );

  // A run that has just ended is no longer busy.
  `I2CBR_ASSERT(a_finish_idle, clk_i, rst_ni, finished_o |-> !busy_res_o)
  // SCL and SDA are never pulled low together.
  `I2CBR_ASSERT(a_one_pull, clk_i, rst_ni, !(scl_pull_low_o && sda_pull_low_o))
  // A line is only driven during a run.
  `I2CBR_ASSERT(a_pull_busy, clk_i, rst_ni, (scl_pull_low_o || sda_pull_low_o) |-> busy_res_o)
  // A step always leaves a result to be taken.
  `I2CBR_ASSERT(a_step_out, clk_i, rst_ni, step |=> out_valid_o)
  // Register writes are never held off, not even in reset.
  `I2CBR_ASSERT_ALWAYS(a_cfg_ready, clk_i, cfg_ready_o)

endmodule

// ===== rtl/i2cbr_cfg.sv =====
// Configuration register bank of the I2C bus recovery sequencer.
// Depends on i2cbr_pkg.
module i2cbr_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [i2cbr_pkg::CfgIndexW-1:0]   cfg_index_i,
  input  logic [i2cbr_pkg::CfgDataW-1:0]    cfg_data_i,
  output i2cbr_pkg::cfg_t                   cfg_o
);
  import i2cbr_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  // Writes are always taken.
  assign cfg_ready_o = 1'b1;
  assign wr_en       = cfg_valid_i & cfg_ready_o;

  // Decode the register index; unknown indexes leave everything unchanged.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_SETTLE: cfg_d.settle_ticks      = cfg_data_i[SettleW-1:0];
        CFG_HALF:   cfg_d.half_period_ticks = cfg_data_i[HalfW-1:0];
        CFG_POLL:   cfg_d.poll_ticks        = cfg_data_i[PollW-1:0];
        CFG_PLIMIT: cfg_d.poll_limit        = cfg_data_i[CountW-1:0];
        CFG_CLIMIT: cfg_d.clock_limit       = cfg_data_i[CountW-1:0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  // Register bank with its documented reset values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.settle_ticks      <= SettleRst;
      cfg_q.half_period_ticks <= HalfRst;
      cfg_q.poll_ticks        <= PollRst;
      cfg_q.poll_limit        <= PLimitRst;
      cfg_q.clock_limit       <= CLimitRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/i2cbr_seq.sv =====
// Recovery state machine: wait counter, pulse and poll budgets, outcome.
// Depends on i2cbr_pkg; its state registers double as the result register.
module i2cbr_seq #(
  parameter int unsigned TIMER_BITS = i2cbr_pkg::TimerBitsDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  i2cbr_pkg::item_t item_i,
  input  i2cbr_pkg::cfg_t  cfg_i,
  output logic             scl_pull_low_o,
  output logic             sda_pull_low_o,
  output logic             busy_res_o,
  output logic             finished_o,
  output logic [1:0]       outcome_o
);
  import i2cbr_pkg::*;

  phase_e                phase_q, phase_d;
  logic [TIMER_BITS-1:0] wait_q, wait_d;
  logic [CountW-1:0]     clocks_q, clocks_d;
  logic [CountW-1:0]     polls_q, polls_d;
  outcome_e              outc_q, outc_d;
  logic                  done_q, done_d;

  logic [TIMER_BITS-1:0] half_load, settle_load, poll_load;
  logic [CountW-1:0]     clk_cur;
  logic [CountW-1:0]     polls_dec;
  logic                  decide;

  // Clamp a counter load to what the wait counter can hold.
  function automatic logic [TIMER_BITS-1:0] load_f(input logic [31:0] v);
    logic [31:0] hi;
    hi = v >> TIMER_BITS;
    if (hi != 32'd0) load_f = '1;
    else             load_f = v[TIMER_BITS-1:0];
  endfunction

  assign settle_load = load_f(32'(cfg_i.settle_ticks));
  assign half_load   = load_f(32'(cfg_i.half_period_ticks));
  assign poll_load   = load_f(32'(cfg_i.poll_ticks));

  // The pulse budget is reloaded when the settle wait ends.
  assign clk_cur   = (phase_q == PH_SETTLE) ? cfg_i.clock_limit : clocks_q;
  assign polls_dec = polls_q - CountW'(1);

  // Next state for one request.
  always_comb begin
    phase_d  = phase_q;
    wait_d   = wait_q;
    clocks_d = clocks_q;
    polls_d  = polls_q;
    outc_d   = outc_q;
    done_d   = 1'b0;
    decide   = 1'b0;

    if (item_i.kind) begin
      // A start only begins a run from idle.
      if (phase_q == PH_IDLE) begin
        phase_d = PH_SETTLE;
        wait_d  = settle_load;
      end
    end else if (phase_q != PH_IDLE) begin
      if (wait_q > TIMER_BITS'(1)) begin
        wait_d = wait_q - TIMER_BITS'(1);
      end else begin
        wait_d = '0;
        unique case (phase_q)
          PH_SETTLE: begin
            if (!item_i.scl_level) begin
              outc_d  = OUT_SCL_LOW;
              phase_d = PH_IDLE;
              done_d  = 1'b1;
            end else begin
              decide = 1'b1;
            end
          end
          PH_LOW: begin
            phase_d = PH_HIGH;
            wait_d  = half_load;
          end
          PH_HIGH: begin
            if (!item_i.scl_level) begin
              // A slave stretches the clock: start polling.
              polls_d = cfg_i.poll_limit;
              if (cfg_i.poll_limit == '0) begin
                outc_d  = OUT_STRETCH;
                phase_d = PH_IDLE;
                done_d  = 1'b1;
              end else begin
                phase_d = PH_POLL;
                wait_d  = poll_load;
              end
            end else begin
              decide = 1'b1;
            end
          end
          PH_POLL: begin
            polls_d = polls_dec;
            if (item_i.scl_level) begin
              decide = 1'b1;
            end else if (polls_dec == '0) begin
              outc_d  = OUT_STRETCH;
              phase_d = PH_IDLE;
              done_d  = 1'b1;
            end else begin
              wait_d = poll_load;
            end
          end
          PH_START: begin
            phase_d = PH_STOP;
            wait_d  = half_load;
          end
          PH_STOP: begin
            outc_d  = OUT_CLEARED;
            phase_d = PH_IDLE;
            done_d  = 1'b1;
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase
      end
    end

    // SCL is known high here; SDA decides between another pulse,
    // giving up, or the closing START and STOP.
    if (decide) begin
      clocks_d = clk_cur;
      if (!item_i.sda_level && (clk_cur != '0)) begin
        clocks_d = clk_cur - CountW'(1);
        phase_d  = PH_LOW;
        wait_d   = half_load;
      end else if (!item_i.sda_level) begin
        outc_d  = OUT_SDA_LOW;
        phase_d = PH_IDLE;
        wait_d  = '0;
        done_d  = 1'b1;
      end else begin
        phase_d = PH_START;
        wait_d  = half_load;
      end
    end
  end

  // State registers advance once per request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      wait_q   <= '0;
      clocks_q <= '0;
      polls_q  <= '0;
      outc_q   <= OUT_CLEARED;
      done_q   <= 1'b0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      wait_q   <= wait_d;
      clocks_q <= clocks_d;
      polls_q  <= polls_d;
      outc_q   <= outc_d;
      done_q   <= done_d;
    end
  end

  // The result shows the state after the latest request.
  assign scl_pull_low_o = (phase_q == PH_LOW);
  assign sda_pull_low_o = (phase_q == PH_START);
  assign busy_res_o     = (phase_q != PH_IDLE);
  assign finished_o     = done_q;
  assign outcome_o      = outc_q;

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the I2C bus recovery sequencer unit.
// Depends on i2cbr_pkg and i2c_bus_recovery_sequencer_unit; drives random requests and
// register settings and checks every result against its own model of the recovery run.
`timescale 1ns / 100ps

module testbench;
  import i2cbr_pkg::*;

  localparam int unsigned TimerBits = TimerBitsDefault;

  // Request kinds on the input channel.
  localparam logic KindTick  = 1'b0;
  localparam logic KindStart = 1'b1;

  // First register index past the end of the register list.
  localparam logic [CfgIndexW-1:0] FirstSpareIdx = 3'd5;

  // Idle percentage of each side and the gap-free stretch inside each window.
  localparam int unsigned IdlePct     = 17;
  localparam int unsigned GapWindow   = 6000;
  localparam int unsigned GapFreeSpan = 1500;

  typedef struct packed {
    logic kind;
    logic scl;
    logic sda;
  } line_req_t;

  typedef struct packed {
    logic     scl_pull_low;
    logic     sda_pull_low;
    logic     busy;
    logic     finished;
    outcome_e outcome;
  } bus_status_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic                 kind_i = 1'b0;
  logic                 scl_level_i = 1'b0;
  logic                 sda_level_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic                 scl_pull_low_o;
  logic                 sda_pull_low_o;
  logic                 busy_res_o;
  logic                 finished_o;
  logic [1:0]           outcome_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIndexW-1:0] cfg_index_i = '0;
  logic [CfgDataW-1:0]  cfg_data_i = '0;

  // Requests waiting to be driven and results waiting to be seen.
  line_req_t   pending_reqs[$];
  bus_status_t expected_status_q[$];
  line_req_t   next_req;
  bus_status_t seen_status;
  bus_status_t due_status;
  int unsigned reqs_queued = 0;
  int unsigned reqs_taken = 0;
  int unsigned failures = 0;
  int unsigned cycle_count = 0;
  bit          req_taken = 1'b0;
  bit          no_gaps;

  // Model state of the recovery run and its copy of the registers.
  cfg_t                 reg_shadow = '{SettleRst, HalfRst, PollRst, PLimitRst, CLimitRst};
  phase_e               rec_phase = PH_IDLE;
  logic [TimerBits-1:0] wait_left = '0;
  logic [CountW-1:0]    clocks_left = '0;
  logic [CountW-1:0]    polls_left = '0;
  outcome_e             last_outcome = OUT_CLEARED;
  bit                   run_ended = 1'b0;
  int unsigned          runs_done = 0;

  i2c_bus_recovery_sequencer_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .scl_level_i    (scl_level_i),
    .sda_level_i    (sda_level_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .scl_pull_low_o (scl_pull_low_o),
    .sda_pull_low_o (sda_pull_low_o),
    .busy_res_o     (busy_res_o),
    .finished_o     (finished_o),
    .outcome_o      (outcome_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // A counter load saturates at the top of the wait timer.
  function automatic logic [TimerBits-1:0] timer_value(longint unsigned ticks);
    longint unsigned top;
    top = (64'd1 << TimerBits) - 1;
    if (ticks > top) return '1;
    return ticks[TimerBits-1:0];
  endfunction

  function automatic void end_run(outcome_e code);
    last_outcome = code;
    rec_phase    = PH_IDLE;
    wait_left    = '0;
    run_ended    = 1'b1;
    runs_done++;
  endfunction

  // With SCL known high: pulse again while SDA is stuck, else give up or send START.
  function automatic void pulse_or_start(logic sda);
    if (!sda && clocks_left != 0) begin
      clocks_left = clocks_left - 1'b1;
      rec_phase   = PH_LOW;
      wait_left   = timer_value(reg_shadow.half_period_ticks);
    end else if (!sda) begin
      end_run(OUT_SDA_LOW);
    end else begin
      rec_phase = PH_START;
      wait_left = timer_value(reg_shadow.half_period_ticks);
    end
  endfunction

  // Advances the recovery run by one request and returns the line status after it.
  function automatic bus_status_t advance_recovery(logic kind, logic scl, logic sda);
    bus_status_t st;
    run_ended = 1'b0;
    if (kind == KindStart) begin
      // A start while a run is going on is ignored.
      if (rec_phase == PH_IDLE) begin
        rec_phase = PH_SETTLE;
        wait_left = timer_value(reg_shadow.settle_ticks);
      end
    end else if (rec_phase != PH_IDLE) begin
      if (wait_left > 1) begin
        wait_left = wait_left - 1'b1;
      end else begin
        // The wait ends on this tick, and the sampled lines decide the next step.
        wait_left = '0;
        case (rec_phase)
          PH_SETTLE: begin
            if (!scl) begin
              end_run(OUT_SCL_LOW);
            end else begin
              clocks_left = reg_shadow.clock_limit;
              pulse_or_start(sda);
            end
          end
          PH_LOW: begin
            rec_phase = PH_HIGH;
            wait_left = timer_value(reg_shadow.half_period_ticks);
          end
          PH_HIGH: begin
            if (!scl) begin
              polls_left = reg_shadow.poll_limit;
              if (polls_left == 0) begin
                end_run(OUT_STRETCH);
              end else begin
                rec_phase = PH_POLL;
                wait_left = timer_value(reg_shadow.poll_ticks);
              end
            end else begin
              pulse_or_start(sda);
            end
          end
          PH_POLL: begin
            polls_left = polls_left - 1'b1;
            if (scl) begin
              pulse_or_start(sda);
            end else if (polls_left == 0) begin
              end_run(OUT_STRETCH);
            end else begin
              wait_left = timer_value(reg_shadow.poll_ticks);
            end
          end
          PH_START: begin
            rec_phase = PH_STOP;
            wait_left = timer_value(reg_shadow.half_period_ticks);
          end
          PH_STOP: begin
            end_run(OUT_CLEARED);
          end
          default: begin
            rec_phase = PH_IDLE;
          end
        endcase
      end
    end
    st.scl_pull_low = (rec_phase == PH_LOW);
    st.sda_pull_low = (rec_phase == PH_START);
    st.busy         = (rec_phase != PH_IDLE);
    st.finished     = run_ended;
    st.outcome      = last_outcome;
    return st;
  endfunction

  function automatic void check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      failures++;
    end
  endfunction

  // Driver: presents the next request at the falling edge and stalls results at random.
  always @(negedge clk_i) begin
    cycle_count++;
    no_gaps = (cycle_count % GapWindow) < GapFreeSpan;
    if (rst_ni && (!in_valid_i || req_taken)) begin
      if (pending_reqs.size() != 0 && (no_gaps || $urandom_range(0, 99) >= IdlePct)) begin
        next_req = pending_reqs.pop_front();
        in_valid_i  <= 1'b1;
        kind_i      <= next_req.kind;
        scl_level_i <= next_req.scl;
        sda_level_i <= next_req.sda;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    req_taken = 1'b0;
    out_stall_i <= !no_gaps && ($urandom_range(0, 99) < IdlePct);
  end

  // Monitor: takes accepted requests and register writes into the model, checks results.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_status_q.insert(expected_status_q.size(),
                                 advance_recovery(kind_i, scl_level_i, sda_level_i));
        reqs_taken++;
        req_taken = 1'b1;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_SETTLE: reg_shadow.settle_ticks      = cfg_data_i[SettleW-1:0];
          CFG_HALF:   reg_shadow.half_period_ticks = cfg_data_i[HalfW-1:0];
          CFG_POLL:   reg_shadow.poll_ticks        = cfg_data_i[PollW-1:0];
          CFG_PLIMIT: reg_shadow.poll_limit        = cfg_data_i[CountW-1:0];
          CFG_CLIMIT: reg_shadow.clock_limit       = cfg_data_i[CountW-1:0];
          default: ;
        endcase
      end
      if (out_valid_o && !out_stall_i) begin
        seen_status = '{scl_pull_low_o, sda_pull_low_o, busy_res_o, finished_o,
                        outcome_e'(outcome_o)};
        if (expected_status_q.size() == 0) begin
          $error("result with no request pending: %p", seen_status);
          failures++;
        end else begin
          due_status = expected_status_q.pop_front();
          check_field("scl_pull_low", due_status.scl_pull_low, scl_pull_low_o);
          check_field("sda_pull_low", due_status.sda_pull_low, sda_pull_low_o);
          check_field("busy_res", due_status.busy, busy_res_o);
          check_field("finished", due_status.finished, finished_o);
          check_field("outcome", due_status.outcome, outcome_o);
        end
      end
    end
  end

  task automatic queue_req(logic kind, logic scl, logic sda);
    line_req_t req;
    req = '{kind, scl, sda};
    pending_reqs.insert(pending_reqs.size(), req);
    reqs_queued++;
  endtask

  // Waits until every request is taken and every result seen, then lets the pipe drain.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (reqs_taken != reqs_queued || expected_status_q.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  // Leaves valid high across back-to-back writes; the caller lowers it afterwards.
  task automatic write_reg(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i);
    while (!cfg_ready_o);
  endtask

  // Writes all registers, with junk above each field narrower than the data word, plus one write to a spare index.
  task automatic program_regs(int unsigned settle, int unsigned half, int unsigned poll,
                              int unsigned plimit, int unsigned climit);
    logic [CfgDataW-1:0] word;
    word = settle[SettleW-1:0];
    write_reg(CFG_SETTLE, word);
    word = CfgDataW'($urandom());
    word[HalfW-1:0] = half[HalfW-1:0];
    write_reg(CFG_HALF, word);
    word = CfgDataW'($urandom());
    word[PollW-1:0] = poll[PollW-1:0];
    write_reg(CFG_POLL, word);
    word = CfgDataW'($urandom());
    word[CountW-1:0] = plimit[CountW-1:0];
    write_reg(CFG_PLIMIT, word);
    word = CfgDataW'($urandom());
    word[CountW-1:0] = climit[CountW-1:0];
    write_reg(CFG_CLIMIT, word);
    write_reg(FirstSpareIdx + 3'($urandom_range(0, 2)), CfgDataW'($urandom()));
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Full recovery runs: a start, then ticks with biased line levels until the run ends.
  task automatic run_recoveries(int unsigned count);
    int unsigned scl_low_pct;
    int unsigned sda_high_pct;
    int unsigned goal;
    repeat (count) begin
      case ($urandom_range(0, 3))
        0: scl_low_pct = 0;
        1: scl_low_pct = 5;
        2: scl_low_pct = 30;
        default: scl_low_pct = 90;
      endcase
      case ($urandom_range(0, 3))
        0: sda_high_pct = 0;
        1: sda_high_pct = 15;
        2: sda_high_pct = 50;
        default: sda_high_pct = 100;
      endcase
      // Some noise first: ticks on an idle sequencer.
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 4)) queue_req(KindTick, 1'($urandom()), 1'($urandom()));
      end
      queue_req(KindStart, 1'($urandom()), 1'($urandom()));
      goal = runs_done + 1;
      while (runs_done < goal) begin
        if (pending_reqs.size() < 3) begin
          // A start in the middle of a run is ignored by the sequencer.
          if ($urandom_range(0, 99) < 3) begin
            queue_req(KindStart, 1'($urandom()), 1'($urandom()));
          end else begin
            queue_req(KindTick, $urandom_range(0, 99) >= scl_low_pct,
                      $urandom_range(0, 99) < sda_high_pct);
          end
        end
        @(negedge clk_i);
      end
    end
  endtask

  // Stimulus: directed cases, extreme settings, random phases, then one long run.
  initial begin
    int unsigned random_from;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: one tick per wait, one pulse, one poll.
    program_regs(1, 1, 1, 1, 1);
    queue_req(KindTick, 1'b0, 1'b0);   // tick while idle
    queue_req(KindStart, 1'b0, 1'b1);
    queue_req(KindStart, 1'b1, 1'b0);  // start while busy
    queue_req(KindTick, 1'b0, 1'b1);   // SCL low after settling
    queue_req(KindStart, 1'b1, 1'b1);
    queue_req(KindTick, 1'b1, 1'b0);
    queue_req(KindTick, 1'b1, 1'b1);
    queue_req(KindTick, 1'b0, 1'b1);
    queue_req(KindTick, 1'b0, 1'b0);   // stretch never released
    queue_req(KindStart, 1'b0, 1'b0);
    queue_req(KindTick, 1'b1, 1'b0);
    queue_req(KindTick, 1'b0, 1'b0);
    queue_req(KindTick, 1'b1, 1'b0);   // SDA still low, pulse budget spent
    queue_req(KindStart, 1'b1, 1'b1);
    queue_req(KindTick, 1'b1, 1'b1);
    queue_req(KindTick, 1'b0, 1'b0);
    queue_req(KindTick, 1'b1, 1'b0);   // bus cleared
    queue_req(KindStart, 1'b0, 1'b1);
    queue_req(KindTick, 1'b1, 1'b0);
    queue_req(KindTick, 1'b1, 1'b0);
    queue_req(KindTick, 1'b0, 1'b0);
    queue_req(KindTick, 1'b1, 1'b1);   // stretch released within the poll limit
    queue_req(KindTick, 1'b1, 1'b1);
    queue_req(KindTick, 1'b1, 1'b1);
    wait_idle();

    // Zero waits end on the first tick; zero limits end at once.
    program_regs(0, 0, 0, 0, 0);
    run_recoveries(6);
    wait_idle();

    // Largest pulse and poll budgets.
    program_regs(3, 1, 0, 63, 63);
    run_recoveries(4);
    wait_idle();

    // Every register at its top; only idle ticks, since a settle this long is not run.
    program_regs(22'h3FFFFF, 1023, 262143, 63, 63);
    repeat (8) queue_req(KindTick, 1'($urandom()), 1'($urandom()));
    wait_idle();

    // Random settings, mostly short so that many runs fit.
    random_from = reqs_queued;
    while (reqs_queued - random_from < 600) begin
      program_regs($urandom_range(0, 99) < 15 ? $urandom_range(0, 200) : $urandom_range(0, 12),
                   $urandom_range(0, 99) < 15 ? $urandom_range(0, 30) : $urandom_range(0, 4),
                   $urandom_range(0, 6), $urandom_range(0, 6), $urandom_range(0, 8));
      run_recoveries(6);
      wait_idle();
    end

    // One pulse at a long half period, then a stretch over a long poll.
    program_regs(3, 40, 100, 1, 1);
    queue_req(KindStart, 1'b1, 1'b1);
    repeat (3) queue_req(KindTick, 1'b1, 1'b0);
    repeat (40 + 39) queue_req(KindTick, 1'($urandom()), 1'($urandom()));
    queue_req(KindTick, 1'b0, 1'($urandom()));
    repeat (100) queue_req(KindTick, 1'b0, 1'($urandom()));
    repeat (4) queue_req(KindTick, 1'($urandom()), 1'($urandom()));
    wait_idle();

    repeat (10) @(negedge clk_i);
    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog, several times the slowest correct run.
  initial begin
    #5000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/i2cbr_pkg.sv
rtl/i2cbr_cfg.sv
rtl/i2cbr_seq.sv
rtl/i2c_bus_recovery_sequencer_unit.sv
dv/testbench.sv
